// ----- src/pq_pkg.sv -----
// Package for the sorted priority queue: operation and status codes,
// entry and result records, sequencer states. No dependencies.
`default_nettype none

package pq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int ID_W          = 16;
  localparam int PRIO_W        = 8;
  localparam int PAGES_W       = 16;
  localparam int COUNT_OUT_W   = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_MODIFY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [PAGES_W-1:0] pages;
  } entry_t;

  typedef struct packed {
    status_t                status;
    logic [COUNT_OUT_W-1:0] ahead_count;
    logic [PRIO_W-1:0]      found_priority;
    logic [PAGES_W-1:0]     found_pages;
    logic [COUNT_OUT_W-1:0] entries_left;
    logic [PRIO_W-1:0]      top_priority;
    logic                   queue_empty;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_TAKE,
    S_PUT,
    S_PLACE,
    S_FINISH
  } seq_state_t;

endpackage

`default_nettype wire

// ----- src/pq_store.sv -----
// Entry memory of the priority queue: one write port, one registered read port.
// Depends on pq_pkg.
`default_nettype none

module pq_store import pq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT,
  parameter int AddrW       = $clog2(QUEUE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AddrW-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic [AddrW-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- src/pq_seq.sv -----
// Sequencer of the priority queue: scans, shifts and places entries one slot
// a cycle through the entry memory. Depends on pq_pkg.
`default_nettype none

module pq_seq import pq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT,
  parameter int AddrW       = $clog2(QUEUE_DEPTH)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic [ID_W-1:0]    doc_id,
  input  wire logic [PRIO_W-1:0]  priority_req,
  input  wire logic [PAGES_W-1:0] pages,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output result_t                 res,
  output logic                    wr_en,
  output logic [AddrW-1:0]        wr_addr,
  output entry_t                  wr_data,
  output logic [AddrW-1:0]        rd_addr,
  input  wire entry_t             rd_data
);

  localparam int CntW = AddrW + 1;

  seq_state_t         state, state_next;
  logic [CntW-1:0]    count, count_next;
  op_t                op_r, op_r_next;
  logic [ID_W-1:0]    key_id, key_id_next;
  logic [PRIO_W-1:0]  key_prio, key_prio_next;
  logic [PAGES_W-1:0] key_pages, key_pages_next;
  logic [AddrW-1:0]   idx, idx_next;
  logic [AddrW-1:0]   pos, pos_next;
  logic [AddrW-1:0]   ahead, ahead_next;
  logic [PRIO_W-1:0]  top_prio, top_prio_next;
  status_t            status_r, status_r_next;
  logic [PRIO_W-1:0]  fprio, fprio_next;
  logic [PAGES_W-1:0] fpages, fpages_next;
  logic [CntW-1:0]    idx_p1, idx_p2;

  assign idx_p1 = CntW'(idx) + CntW'(1);
  assign idx_p2 = CntW'(idx) + CntW'(2);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_r_next;
    key_id    <= key_id_next;
    key_prio  <= key_prio_next;
    key_pages <= key_pages_next;
    idx       <= idx_next;
    pos       <= pos_next;
    ahead     <= ahead_next;
    top_prio  <= top_prio_next;
    status_r  <= status_r_next;
    fprio     <= fprio_next;
    fpages    <= fpages_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    op_r_next      = op_r;
    key_id_next    = key_id;
    key_prio_next  = key_prio;
    key_pages_next = key_pages;
    idx_next       = idx;
    pos_next       = pos;
    ahead_next     = ahead;
    top_prio_next  = top_prio;
    status_r_next  = status_r;
    fprio_next     = fprio;
    fpages_next    = fpages;
    wr_en          = 1'b0;
    wr_addr        = idx;
    wr_data        = rd_data;
    rd_addr        = idx;
    res_valid      = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_r_next      = op_t'(operation);
          key_id_next    = doc_id;
          key_prio_next  = priority_req;
          key_pages_next = pages;
          status_r_next  = ST_OK;
          fprio_next     = '0;
          fpages_next    = '0;
          ahead_next     = '0;
          if (operation == OP_INSERT) begin
            if (count == CntW'(QUEUE_DEPTH)) begin
              status_r_next = ST_FULL;
              state_next    = S_FINISH;
            end else if (count == '0) begin
              pos_next   = '0;
              state_next = S_PLACE;
            end else begin
              // walk up from the tail
              idx_next   = AddrW'(count - CntW'(1));
              rd_addr    = AddrW'(count - CntW'(1));
              state_next = S_PUT;
            end
          end else if (count == '0) begin
            status_r_next = ST_NOT_FOUND;
            state_next    = S_FINISH;
          end else begin
            idx_next   = '0;
            rd_addr    = '0;
            state_next = S_FIND;
          end
        end
      end

      S_FIND: begin
        if (rd_data.id == key_id) begin
          fprio_next  = rd_data.prio;
          fpages_next = rd_data.pages;
          if (op_r == OP_LOOKUP) begin
            state_next = S_FINISH;
          end else begin
            rd_addr    = AddrW'(idx_p1);
            state_next = S_TAKE;
          end
        end else if (idx_p1 == count) begin
          status_r_next = ST_NOT_FOUND;
          state_next    = S_FINISH;
        end else begin
          idx_next = AddrW'(idx_p1);
          rd_addr  = AddrW'(idx_p1);
        end
      end

      S_TAKE: begin
        if (idx_p1 < count) begin
          // close the gap: slot idx takes its successor
          wr_en    = 1'b1;
          wr_addr  = idx;
          wr_data  = rd_data;
          idx_next = AddrW'(idx_p1);
          rd_addr  = AddrW'(idx_p2);
        end else begin
          count_next = count - CntW'(1);
          if (op_r == OP_MODIFY) begin
            if (count == CntW'(1)) begin
              pos_next   = '0;
              state_next = S_PLACE;
            end else begin
              idx_next   = AddrW'(count - CntW'(2));
              rd_addr    = AddrW'(count - CntW'(2));
              state_next = S_PUT;
            end
          end else begin
            state_next = S_FINISH;
          end
        end
      end

      S_PUT: begin
        if (rd_data.prio < key_prio) begin
          // lower priority moves one slot back
          wr_en   = 1'b1;
          wr_addr = AddrW'(idx_p1);
          wr_data = rd_data;
          if (idx == '0) begin
            pos_next   = '0;
            state_next = S_PLACE;
          end else begin
            idx_next = idx - AddrW'(1);
            rd_addr  = idx - AddrW'(1);
          end
        end else begin
          pos_next   = AddrW'(idx_p1);
          state_next = S_PLACE;
        end
      end

      S_PLACE: begin
        wr_en         = 1'b1;
        wr_addr       = pos;
        wr_data.id    = key_id;
        wr_data.prio  = key_prio;
        wr_data.pages = key_pages;
        ahead_next    = pos;
        count_next    = count + CntW'(1);
        state_next    = S_FINISH;
      end

      S_FINISH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    // track the head priority alongside the memory
    if (wr_en && (wr_addr == '0)) begin
      top_prio_next = wr_data.prio;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    res.status         = status_r;
    res.ahead_count    = COUNT_OUT_W'(ahead);
    res.found_priority = fprio;
    res.found_pages    = fpages;
    res.entries_left   = COUNT_OUT_W'(count);
    res.top_priority   = (count != '0) ? top_prio : '0;
    res.queue_empty    = (count == '0);
  end

endmodule

`default_nettype wire

// ----- src/priority_queue_with_id_ops.sv -----
// Sorted priority queue with operations by id: top level.
// Holds pq_seq, pq_store and the result register. Depends on pq_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command per transaction:
//   operation (insert, remove, lookup, modify), doc_id, priority_req, pages.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   command: status, ahead_count, found_priority, found_pages, entries_left,
//   top_priority and queue_empty.
//   Entries are kept in descending priority; equal priorities keep arrival
//   order. Every step walks the entry memory one slot a cycle, so the time
//   from one accepted command to the next is shortest for an insert into a
//   full queue or an id command on an empty one, and longest for a modify
//   in a full queue that sends the entry to the head: scan and gap closing,
//   then the walk back from the tail and the place. in_stall stays high
//   until the result enters the output reg, and only then can it drop.
//   The output register holds a result while out_stall is high; a new
//   command may be accepted meanwhile, its result waiting in the sequencer.
//   Synchronous reset empties the queue and drops any held result; the
//   memory is not cleared, as only slots below the entry count are read.
`default_nettype none

module priority_queue_with_id_ops import pq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         operation,
  input  wire logic [ID_W-1:0]    doc_id,
  input  wire logic [PRIO_W-1:0]  priority_req,
  input  wire logic [PAGES_W-1:0] pages,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [1:0]              status,
  output logic [4:0]              ahead_count,
  output logic [PRIO_W-1:0]       found_priority,
  output logic [PAGES_W-1:0]      found_pages,
  output logic [4:0]              entries_left,
  output logic [PRIO_W-1:0]       top_priority,
  output logic                    queue_empty
);

  localparam int AddrW = $clog2(QUEUE_DEPTH);

  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  entry_t           wr_data;
  logic [AddrW-1:0] rd_addr;
  entry_t           rd_data;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  result_t          res_q;

  pq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AddrW       (AddrW)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .doc_id       (doc_id),
    .priority_req (priority_req),
    .pages        (pages),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data)
  );

  pq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AddrW       (AddrW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign status         = res_q.status;
  assign ahead_count    = res_q.ahead_count;
  assign found_priority = res_q.found_priority;
  assign found_pages    = res_q.found_pages;
  assign entries_left   = res_q.entries_left;
  assign top_priority   = res_q.top_priority;
  assign queue_empty    = res_q.queue_empty;

endmodule

`default_nettype wire

// ----- src/pq_checker.sv -----
// Port-level checks for the priority queue, bound to the top level.
// Depends on pq_pkg and priority_queue_with_id_ops.
`default_nettype none

module pq_checker import pq_pkg::*; (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         status,
  input wire logic [4:0]         ahead_count,
  input wire logic [PRIO_W-1:0]  found_priority,
  input wire logic [PAGES_W-1:0] found_pages,
  input wire logic [4:0]         entries_left,
  input wire logic [PRIO_W-1:0]  top_priority,
  input wire logic               queue_empty
);

  // reset drops any held result
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result still valid after reset");

  // one command at a time: busy straight after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after a transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(status) &&
      $stable(found_pages) && $stable(entries_left)))
    else $error("stalled result changed");

  a_empty_view: assert property (@(posedge clk) disable iff (rst)
    (out_valid && queue_empty) |-> (entries_left == '0 && top_priority == '0))
    else $error("empty queue reports entries or a head priority");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status == ST_FULL || status == ST_NOT_FOUND)) |->
      (ahead_count == '0 && found_priority == '0 && found_pages == '0))
    else $error("failed command reports non-zero fields");

endmodule

bind priority_queue_with_id_ops pq_checker u_pq_checker (.*);

`default_nettype wire
